FILE: src/tmcs_pkg.sv
// tmcs_pkg: widths, reset values and shared types for the trimmed-mean channel scanner
// no dependencies; imported by the interfaces and every module of the block
package tmcs_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int CH_W        = 4;
  localparam int IDX_W       = 4;
  localparam int SUM_W       = 16;
  localparam int THR_W       = 16;
  localparam int STATUS_W    = 16;
  localparam int REG_W       = 64;
  localparam int REG_COUNT   = 4;
  localparam int LANES       = REG_W / THR_W;
  localparam int CFG_INDEX_W = 8;

  localparam int SAMPLES_PER_MEASURE = 10;
  localparam int AVG_SHIFT           = 3;

  localparam logic [IDX_W-1:0]    LAST_INDEX   = IDX_W'(SAMPLES_PER_MEASURE - 1);
  localparam logic [SAMPLE_W-1:0] SMALLEST_RST = '1;
  localparam logic [THR_W-1:0]    THR_DEFAULT  = 16'd1900;
  localparam logic [REG_W-1:0]    THR_REG_RST  = {LANES{THR_DEFAULT}};

  typedef logic [REG_COUNT-1:0][REG_W-1:0] thr_regs_t;

  typedef struct packed {
    logic [CH_W-1:0]     measured_channel;
    logic [SAMPLE_W-1:0] trimmed_average;
    logic                above_threshold;
    logic                scan_complete;
    logic [STATUS_W-1:0] inverted_status;
    logic [CH_W-1:0]     next_channel;
  } result_t;

endpackage

FILE: src/tmcs_if.sv
// tmcs channel interfaces: sample input, result output and register write port
// depends on tmcs_pkg for field widths
interface tmcs_sample_if;
  import tmcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tmcs_result_if;
  import tmcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     measured_channel;
  logic [SAMPLE_W-1:0] trimmed_average;
  logic                above_threshold;
  logic                scan_complete;
  logic [STATUS_W-1:0] inverted_status;
  logic [CH_W-1:0]     next_channel;
  modport source (output valid, output measured_channel, output trimmed_average,
                  output above_threshold, output scan_complete, output inverted_status,
                  output next_channel, input ready);
  modport sink (input valid, input measured_channel, input trimmed_average,
                input above_threshold, input scan_complete, input inverted_status,
                input next_channel, output ready);
endinterface

interface tmcs_cfg_if;
  import tmcs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [REG_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/trimmed_mean_channel_scan_comparator_top.sv
// Trimmed-mean channel scanner: one 12-bit sample word is taken per clock, back to back.
// Every tenth sample closes a measurement of the selected channel and a result word
// is registered from the sample register into the output register; the rate is
// set by the sum/max/min update in the sample stage, which stalls only
// when a finishing sample meets a full output register. Thresholds reset to 1900.
// depends on tmcs_pkg, tmcs_if, tmcs_cfg_regs and tmcs_core
module trimmed_mean_channel_scan_comparator_top #(
  parameter int CHANNEL_COUNT = 16
) (
  input logic           clk,
  input logic           rst,
  tmcs_sample_if.sink   sample,
  tmcs_result_if.source result,
  tmcs_cfg_if.sink      cfg
);
  import tmcs_pkg::*;

  thr_regs_t thresholds;

  tmcs_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .thresholds (thresholds)
  );

  tmcs_core #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .result     (result),
    .thresholds (thresholds)
  );

endmodule

FILE: src/tmcs_cfg_regs.sv
// tmcs_cfg_regs: the four packed threshold registers behind the write port
// depends on tmcs_pkg and tmcs_cfg_if
module tmcs_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  tmcs_cfg_if.sink            cfg,
  output tmcs_pkg::thr_regs_t thresholds
);
  import tmcs_pkg::*;

  thr_regs_t regs;

  assign cfg.ready  = 1'b1;
  assign thresholds = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= {REG_COUNT{THR_REG_RST}};
    end else if (cfg.valid && cfg.ready && (cfg.index < CFG_INDEX_W'(REG_COUNT))) begin
      regs[cfg.index[$clog2(REG_COUNT)-1:0]] <= cfg.data;
    end
  end

endmodule

FILE: src/tmcs_core.sv
// tmcs_core: sample register, per-channel accumulate/trim/compare and result register
// depends on tmcs_pkg, tmcs_sample_if and tmcs_result_if
module tmcs_core #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  tmcs_sample_if.sink         sample,
  tmcs_result_if.source       result,
  input  tmcs_pkg::thr_regs_t thresholds
);
  import tmcs_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNEL_COUNT - 1);

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [IDX_W-1:0]    sample_index;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] largest_sample;
  logic [SAMPLE_W-1:0] smallest_sample;
  logic [CH_W-1:0]     current_channel;
  logic [STATUS_W-1:0] working_status;
  logic [STATUS_W-1:0] published_status;
  logic                out_valid;
  result_t             res;

  logic                out_free;
  logic                s1_last;
  logic                s1_fire;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] largest_next;
  logic [SAMPLE_W-1:0] smallest_next;
  logic [SUM_W-1:0]    trimmed;
  logic [SAMPLE_W-1:0] avg;
  logic [THR_W-1:0]    thr;
  logic                above;
  logic                done;
  logic [CH_W-1:0]     channel_next;
  logic [STATUS_W-1:0] working_next;
  logic [STATUS_W-1:0] published_next;

  // sample stage only waits when it would finish a measurement into a full output
  assign out_free     = !out_valid || result.ready;
  assign s1_last      = sample_index == LAST_INDEX;
  assign s1_fire      = s1_valid && (!s1_last || out_free);
  assign sample.ready = !s1_valid || s1_fire;

  always_comb begin
    sum_next       = running_sum + SUM_W'(s1_sample);
    largest_next   = (s1_sample > largest_sample) ? s1_sample : largest_sample;
    smallest_next  = (s1_sample < smallest_sample) ? s1_sample : smallest_sample;
    trimmed        = sum_next - SUM_W'(largest_next) - SUM_W'(smallest_next);
    avg            = trimmed[AVG_SHIFT +: SAMPLE_W];
    thr            = thresholds[current_channel[CH_W-1:2]][{current_channel[1:0], 4'b0000} +: THR_W];
    above          = SUM_W'(avg) > thr;
    done           = current_channel == LAST_CH;
    channel_next   = done ? '0 : current_channel + 1'b1;
    working_next   = working_status;
    // channel n owns status bit 15 - n
    working_next[~current_channel] = above;
    published_next = done ? working_next : published_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      sample_index     <= '0;
      running_sum      <= '0;
      largest_sample   <= '0;
      smallest_sample  <= SMALLEST_RST;
      current_channel  <= '0;
      working_status   <= '0;
      published_status <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last) begin
          sample_index     <= '0;
          running_sum      <= '0;
          largest_sample   <= '0;
          smallest_sample  <= SMALLEST_RST;
          current_channel  <= channel_next;
          working_status   <= working_next;
          published_status <= published_next;
        end else begin
          sample_index    <= sample_index + 1'b1;
          running_sum     <= sum_next;
          largest_sample  <= largest_next;
          smallest_sample <= smallest_next;
        end
      end
      if (s1_fire && s1_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_sample <= sample.adc_sample;
    end
    if (s1_fire && s1_last) begin
      res.measured_channel <= current_channel;
      res.trimmed_average  <= avg;
      res.above_threshold  <= above;
      res.scan_complete    <= done;
      res.inverted_status  <= ~published_next;
      res.next_channel     <= channel_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.measured_channel = res.measured_channel;
  assign result.trimmed_average  = res.trimmed_average;
  assign result.above_threshold  = res.above_threshold;
  assign result.scan_complete    = res.scan_complete;
  assign result.inverted_status  = res.inverted_status;
  assign result.next_channel     = res.next_channel;

`ifndef SYNTH
  a_finish_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> out_valid && sample_index == '0 && running_sum == '0)
    else $error("measurement finish did not restart accumulators");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    current_channel <= LAST_CH)
    else $error("channel left the configured range");

  a_scan_wraps: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.scan_complete |-> res.next_channel == '0)
    else $error("scan complete without wrap to channel zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_last))
    else $error("result appeared without a finished measurement");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && !out_free |-> !sample.ready && !s1_fire)
    else $error("finishing sample advanced into a full output");
`endif

endmodule
